[design/assert_macros.svh]
// Assertion macros shared by the design files.
// Needs nothing else; included where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

[design/bech_pkg.sv]
// Package for the byte entropy / chi-square block: word types, sizes, states.
// No dependencies.
`timescale 1ns / 1ps
package bech_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int NUM_BINS   = 256;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int LN_W       = $clog2(CNT_W);
    localparam int T_W        = $clog2(CNT_W * 65536);
    localparam int PROD_W     = CNT_W + T_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int SQ_W       = 2 * CNT_W;
    localparam int DVD_W      = SQ_W + 16;
    localparam int DIVC_W     = $clog2(DVD_W);
    localparam int LOG_ITERS  = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [10:0] byte_count;
        logic [25:0] chi_square_q8;
        logic [19:0] entropy_q16;
        logic        window_overflow;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_UPD,
        S_LSTART,
        S_LOG,
        S_MUL,
        S_RD,
        S_GET,
        S_CHI,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[design/byte_entropy_chi_square.sv]
// Byte histogram entropy and chi-square: accepts one byte word, then stalls input
// while it reads and writes back a 256-entry count memory. On the last byte of a window
// it takes log2 of the byte count, then sweeps the 256 bins, taking log2 of each count
// above one with a bit-serial unit around one 32x32 squarer, then runs two restoring
// divisions of a 38-bit dividend. From acceptance of the last byte to a valid result,
// input is stalled; a stalled result word holds the block in its output state. After
// reset a clearing pass zeroes all 256 entries of the count memory before the first
// byte is taken.
// Depends on bech_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module byte_entropy_chi_square (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bech_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bech_pkg::t_out_word  o_out_data
);

    bech_pkg::t_state r_state, n_state;

    logic [bech_pkg::CNT_W-1:0]  r_mem [bech_pkg::NUM_BINS];
    logic [bech_pkg::CNT_W-1:0]  r_rd;
    logic [bech_pkg::BIN_W-1:0]  mem_ra, mem_wa;
    logic [bech_pkg::CNT_W-1:0]  mem_wd;
    logic                        mem_we;

    logic [bech_pkg::BIN_W-1:0]  r_idx;
    logic [7:0]                  r_byte;
    logic                        r_last;
    logic [bech_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_drop;
    logic [bech_pkg::CNT_W-1:0]  r_k;
    logic                        r_first;
    logic [31:0]                 r_x;
    logic [31:0]                 r_frac;
    logic [bech_pkg::LN_W-1:0]   r_n;
    logic [4:0]                  r_it;
    logic signed [bech_pkg::NUM_W-1:0] r_num;
    logic [bech_pkg::SQ_W-1:0]   r_sumsq;
    logic [bech_pkg::DVD_W-1:0]  r_dvd;
    logic [bech_pkg::CNT_W:0]    r_rem;
    logic [bech_pkg::DIVC_W-1:0] r_dcnt;
    logic                        r_chi_phase;
    logic [25:0]                 r_chi;
    bech_pkg::t_out_word         r_out;
    logic                        r_out_valid;

    logic                        in_acc, upd_en, out_load, bin_end;
    logic [bech_pkg::LN_W-1:0]   lz_n;
    logic [63:0]                 sq;
    logic [32:0]                 sq_t;
    logic [bech_pkg::LN_W+31:0]  log_full;
    logic [bech_pkg::T_W-1:0]    t_val;
    logic [bech_pkg::PROD_W-1:0] prod;
    logic [bech_pkg::SQ_W-1:0]   csq;
    logic [bech_pkg::CNT_W+1:0]  rem_sh;
    logic                        q_bit;
    logic [bech_pkg::DVD_W-1:0]  dvd_nx;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign upd_en   = r_cnt < bech_pkg::CNT_W'(bech_pkg::MAX_WINDOW);
    assign out_load = (r_state == bech_pkg::S_OUT) && (!r_out_valid || !i_out_stall);
    assign bin_end  = r_idx == bech_pkg::BIN_W'(bech_pkg::NUM_BINS - 1);

    always_comb begin
        lz_n = '0;
        for (int b = 0; b < bech_pkg::CNT_W; b++) begin
            if (r_k[b]) begin
                lz_n = bech_pkg::LN_W'(b);
            end
        end
    end

    assign sq       = 64'(r_x) * 64'(r_x);
    assign sq_t     = sq[63:31];
    assign log_full = {r_n, r_frac} + (bech_pkg::LN_W + 32)'(32768);
    assign t_val    = log_full[bech_pkg::T_W+15:16];
    assign prod     = bech_pkg::PROD_W'(r_k) * bech_pkg::PROD_W'(t_val);
    assign csq      = bech_pkg::SQ_W'(r_rd) * bech_pkg::SQ_W'(r_rd);
    assign rem_sh   = {r_rem, r_dvd[bech_pkg::DVD_W-1]};
    assign q_bit    = rem_sh >= (bech_pkg::CNT_W + 2)'(r_cnt);
    assign dvd_nx   = {r_dvd[bech_pkg::DVD_W-2:0], q_bit};

    always_comb begin
        mem_ra = (r_state == bech_pkg::S_IDLE) ? i_in_data.data_byte : r_idx;
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = '0;
        case (r_state)
            bech_pkg::S_CLR: begin
                mem_we = 1'b1;
            end
            bech_pkg::S_UPD: begin
                mem_we = upd_en;
                mem_wa = r_byte;
                mem_wd = r_rd + 1'b1;
            end
            bech_pkg::S_GET: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != bech_pkg::S_IDLE);
        case (r_state)
            bech_pkg::S_CLR:    if (bin_end) n_state = bech_pkg::S_IDLE;
            bech_pkg::S_IDLE:   if (in_acc) n_state = bech_pkg::S_UPD;
            bech_pkg::S_UPD:    n_state = r_last ? bech_pkg::S_LSTART : bech_pkg::S_IDLE;
            bech_pkg::S_LSTART: n_state = bech_pkg::S_LOG;
            bech_pkg::S_LOG:    if (r_it == 5'(bech_pkg::LOG_ITERS - 1)) n_state = bech_pkg::S_MUL;
            bech_pkg::S_MUL: begin
                if (r_first || !bin_end) begin
                    n_state = bech_pkg::S_RD;
                end else begin
                    n_state = bech_pkg::S_CHI;
                end
            end
            bech_pkg::S_RD:     n_state = bech_pkg::S_GET;
            bech_pkg::S_GET: begin
                if (r_rd > bech_pkg::CNT_W'(1)) begin
                    n_state = bech_pkg::S_LSTART;
                end else if (bin_end) begin
                    n_state = bech_pkg::S_CHI;
                end else begin
                    n_state = bech_pkg::S_RD;
                end
            end
            bech_pkg::S_CHI:    n_state = bech_pkg::S_DIV;
            bech_pkg::S_DIV: begin
                if (r_dcnt == bech_pkg::DIVC_W'(bech_pkg::DVD_W - 1) && !r_chi_phase) begin
                    n_state = bech_pkg::S_OUT;
                end
            end
            bech_pkg::S_OUT:    if (out_load) n_state = bech_pkg::S_IDLE;
            default:            n_state = bech_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bech_pkg::S_CLR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                bech_pkg::S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                end
                bech_pkg::S_IDLE: begin
                    r_byte <= i_in_data.data_byte;
                    r_last <= i_in_data.last_byte;
                end
                bech_pkg::S_UPD: begin
                    r_first <= 1'b1;
                    r_num   <= '0;
                    r_sumsq <= '0;
                    r_idx   <= '0;
                    if (upd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_k   <= r_cnt + 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                        r_k    <= r_cnt;
                    end
                end
                bech_pkg::S_LSTART: begin
                    r_x    <= 32'(r_k) << (5'd31 - 5'(lz_n));
                    r_n    <= lz_n;
                    r_frac <= '0;
                    r_it   <= '0;
                end
                bech_pkg::S_LOG: begin
                    r_it   <= r_it + 1'b1;
                    r_frac <= {r_frac[30:0], sq_t[32]};
                    r_x    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                end
                bech_pkg::S_MUL: begin
                    if (r_first) begin
                        r_num <= bech_pkg::NUM_W'(prod);
                    end else begin
                        r_num <= r_num - bech_pkg::NUM_W'(prod);
                        r_idx <= r_idx + 1'b1;
                    end
                    r_first <= 1'b0;
                end
                bech_pkg::S_GET: begin
                    r_sumsq <= r_sumsq + csq;
                    r_k     <= r_rd;
                    if (!(r_rd > bech_pkg::CNT_W'(1)) && !bin_end) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                bech_pkg::S_CHI: begin
                    r_dvd <= {r_sumsq, 16'b0}
                             - ((bech_pkg::DVD_W'(r_cnt) * bech_pkg::DVD_W'(r_cnt)) << 8);
                    r_rem       <= '0;
                    r_dcnt      <= '0;
                    r_chi_phase <= 1'b1;
                end
                bech_pkg::S_DIV: begin
                    if (r_dcnt == bech_pkg::DIVC_W'(bech_pkg::DVD_W - 1) && r_chi_phase) begin
                        r_chi       <= dvd_nx[25:0];
                        r_chi_phase <= 1'b0;
                        r_rem       <= '0;
                        r_dcnt      <= '0;
                        r_dvd       <= r_num[bech_pkg::NUM_W-1] ? '0
                                     : bech_pkg::DVD_W'(r_num[bech_pkg::NUM_W-2:0]);
                    end else begin
                        r_rem  <= q_bit
                                  ? (bech_pkg::CNT_W + 1)'(rem_sh
                                                           - (bech_pkg::CNT_W + 2)'(r_cnt))
                                  : (bech_pkg::CNT_W + 1)'(rem_sh);
                        r_dvd  <= dvd_nx;
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                bech_pkg::S_OUT: begin
                    if (out_load) begin
                        r_out.byte_count      <= 11'(r_cnt);
                        r_out.chi_square_q8   <= r_chi;
                        r_out.entropy_q16     <= r_dvd[19:0];
                        r_out.window_overflow <= r_drop;
                        r_cnt                 <= '0;
                        r_drop                <= 1'b0;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= bech_pkg::CNT_W'(bech_pkg::MAX_WINDOW))
    `ASSERT_IMPLY(a_get_after_rd, i_clk, i_rst_n, (r_state == bech_pkg::S_GET) |-> ($past(r_state) == bech_pkg::S_RD))
    `ASSERT_IMPLY(a_out_loads, i_clk, i_rst_n, out_load |=> (r_out_valid && r_cnt == '0))

endmodule

[tb/byte_entropy_chi_square_checker.sv]
// Scoreboard for byte_entropy_chi_square: watches both word channels, predicts
// each window result from its own histogram and log2 function, compares field by field.
// Depends on bech_pkg.
`timescale 1ns / 1ps
module byte_entropy_chi_square_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bech_pkg::t_in_word  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bech_pkg::t_out_word i_out_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_windows,
    output int                  o_overflows
);

    int unsigned         bin_cnt [bech_pkg::NUM_BINS];
    int unsigned         byte_cnt;
    bit                  dropped;
    bech_pkg::t_out_word results_due [$];

    // round(65536*log2 k) by repeated squaring of the normalized mantissa
    function automatic longint log2_fix(int unsigned k);
        int unsigned     n;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned full;
        n = 0;
        frac = 0;
        if (k == 0) return 0;
        while (n < 31 && (k >> (n + 1)) != 0) n++;
        x = longint'(k) << (31 - n);
        for (int i = 0; i < 32; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        full = (longint'(n) << 32) | frac;
        return longint'((full + 64'h8000) >> 16);
    endfunction

    function automatic bech_pkg::t_out_word window_stats();
        bech_pkg::t_out_word r;
        longint unsigned     len;
        longint unsigned     sumsq;
        longint unsigned     chi;
        longint              num;
        longint              ent;
        len = (byte_cnt == 0) ? 1 : byte_cnt;
        sumsq = 0;
        num = longint'(len) * log2_fix(32'(len));
        for (int i = 0; i < bech_pkg::NUM_BINS; i++) begin
            sumsq += longint'(bin_cnt[i]) * bin_cnt[i];
            num -= longint'(bin_cnt[i]) * log2_fix(bin_cnt[i]);
        end
        chi = (sumsq * 65536 - 256 * len * len) / len;
        ent = (num < 0) ? 0 : num / longint'(len);
        r.byte_count      = byte_cnt[10:0];
        r.chi_square_q8   = chi[25:0];
        r.entropy_q16     = ent[19:0];
        r.window_overflow = dropped;
        return r;
    endfunction

    always @(posedge i_clk) begin
        bech_pkg::t_out_word want;
        if (!i_rst_n) begin
            foreach (bin_cnt[i]) bin_cnt[i] = 0;
            byte_cnt = 0;
            dropped = 0;
            results_due.delete();
            o_errors <= 0;
            o_windows <= 0;
            o_overflows <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result word %p", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = results_due.pop_front();
                    if (want !== i_out_data) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (byte_cnt < bech_pkg::MAX_WINDOW) begin
                    bin_cnt[i_in_data.data_byte]++;
                    byte_cnt++;
                end else begin
                    dropped = 1;
                end
                if (i_in_data.last_byte) begin
                    results_due.push_back(window_stats());
                    o_windows <= o_windows + 1;
                    if (dropped) o_overflows <= o_overflows + 1;
                    foreach (bin_cnt[i]) bin_cnt[i] = 0;
                    byte_cnt = 0;
                    dropped = 0;
                end
            end
        end
        o_pending <= results_due.size();
    end

endmodule

[tb/byte_entropy_chi_square_tb.sv]
// Testbench top for byte_entropy_chi_square: clock, reset, byte-window stimulus
// with bursty sending and patterned output stall; verdict from the checker.
// Depends on bech_pkg, byte_entropy_chi_square, byte_entropy_chi_square_checker.
`timescale 1ns / 1ps
module byte_entropy_chi_square_tb;

    localparam int LIMIT = 4000000;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_in_valid = 0;
    bech_pkg::t_in_word  i_in_data = '0;
    logic                i_out_stall = 0;
    logic                o_in_stall;
    logic                o_out_valid;
    bech_pkg::t_out_word o_out_data;
    int                  errors, pending, windows, overflows;
    int                  cycles = 0;
    int                  words_sent = 0;
    int                  burst_left = 0;

    always #6 i_clk = ~i_clk;

    byte_entropy_chi_square dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    byte_entropy_chi_square_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending), .o_windows(windows),
        .o_overflows(overflows)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("byte_entropy_chi_square regression: fail");
            $finish;
        end
    end

    // receiver stall: mode redrawn each time stall_phase wraps (none, light, heavy, long)
    int stall_mode = 0;
    int stall_phase = 0;
    always @(negedge i_clk) begin
        if (stall_phase == 63) stall_mode <= $urandom_range(0, 3);
        stall_phase <= (stall_phase + 1) % 64;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= (stall_phase[4:3] != 2'b00);
        endcase
    end

    task automatic send_word(input logic [7:0] data, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= '{data_byte: data, last_byte: last};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_window(input int len);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b1);
        for (int i = 0; i < 8; i++) send_word(8'h5A, i == 7);
        for (int i = 0; i < 8; i++) send_word(8'(i * 37), i == 7);

        i_in_valid <= 1'b0;
        wait (pending == 0 && windows == 5);
        @(negedge i_clk);

        // full uniform window plus dropped bytes: chi zero, entropy 8, overflow
        for (int i = 0; i < 1030; i++) send_word(8'(i), i == 1029);
        // long single-value window: large chi, zero entropy
        for (int i = 0; i < 200; i++) send_word(8'hC3, i == 199);
        while (words_sent < 1550) send_window($urandom_range(1, 10));
        i_in_valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(negedge i_clk);
        $display("covered %0d byte words in %0d windows, %0d with dropped bytes",
                 words_sent, windows, overflows);
        if (errors == 0)
            $display("byte_entropy_chi_square regression: pass");
        else
            $display("byte_entropy_chi_square regression: fail");
        $finish;
    end
endmodule
